/* hw/rtl/rgbled_pkg.sv */
// ---------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and color helpers for the RGB LED effect generator.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbled_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SPEED_W    = 4;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned INTERVAL_W = 10;

    localparam logic [INTERVAL_W-1:0] SLOW_BASE_MS  = 10'd620;
    localparam logic [5:0]            SPEED_STEP_MS = 6'd52;
    localparam logic [CHAN_W-1:0]     PULSE_STEP    = 8'd24;
    localparam logic [CHAN_W-1:0]     CHAN_MAX      = 8'd255;
    localparam logic [CHAN_W-1:0]     WHEEL_SEG1    = 8'd85;
    localparam logic [CHAN_W-1:0]     WHEEL_SEG2    = 8'd170;
    localparam logic [CHAN_W-1:0]     RAINBOW_STEP  = 8'd8;
    localparam logic [SPEED_W-1:0]    SPEED_MIN     = 4'd1;
    localparam logic [SPEED_W-1:0]    SPEED_MAX     = 4'd10;

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_PULSE   = 2'd2,
        MODE_RAINBOW = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_EFFECT_MODE  = 3'd0,
        REG_EFFECT_SPEED = 3'd1,
        REG_BASE_RED     = 3'd2,
        REG_BASE_GREEN   = 3'd3,
        REG_BASE_BLUE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        mode_t              mode;
        logic [SPEED_W-1:0] speed;
        rgb_t               base;
    } cfg_t;

    typedef struct packed {
        logic emit;
        rgb_t color;
    } fx_result_t;

    // three-segment color wheel, position read backwards
    function automatic rgb_t color_wheel(input logic [CHAN_W-1:0] pos);
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] seg;
        logic [CHAN_W+1:0] seg3;
        logic [CHAN_W-1:0] up;
        rgb_t              c;
        p = CHAN_MAX - pos;
        if (p < WHEEL_SEG1) begin
            seg = p;
        end else if (p < WHEEL_SEG2) begin
            seg = p - WHEEL_SEG1;
        end else begin
            seg = p - WHEEL_SEG2;
        end
        seg3 = {2'b00, seg} + {1'b0, seg, 1'b0};
        up   = seg3[CHAN_W-1:0];
        if (p < WHEEL_SEG1) begin
            c.red   = CHAN_MAX - up;
            c.green = '0;
            c.blue  = up;
        end else if (p < WHEEL_SEG2) begin
            c.red   = '0;
            c.green = up;
            c.blue  = CHAN_MAX - up;
        end else begin
            c.red   = up;
            c.green = CHAN_MAX - up;
            c.blue  = '0;
        end
        return c;
    endfunction

    // base * level / 255, exact for all 8-bit operands
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] base,
                                                     input logic [CHAN_W-1:0] level);
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W:0]   sum;
        prod = base * level;
        sum  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]}
             + {{(2*CHAN_W){1'b0}}, 1'b1};
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgb_led_effect_generator_unit.sv */
// ---------------------------------------------------------------------------
// rgb_led_effect_generator_unit
// Timestamp-driven blink, pulse and rainbow color generator for an RGB LED.
// ---------------------------------------------------------------------------
// Each item carries a millisecond timestamp; when 620 - 52*speed ms have
// passed since the last update in a mode other than solid, one color item comes out, otherwise none.
// The block takes one item per clock while the result side is not stalled:
// a timestamp is captured in the input register, and once the output register
// has room the effect state and color are worked out from it and land in the
// output register, from which the color is offered on the result port.
// Effect state advances as items leave the input register, which lets each
// item see the state its predecessor left. Configuration writes are registered;
// writing mode or speed restarts the timer, blink and pulse, while the rainbow
// position is kept.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_led_effect_generator_unit
    import rgbled_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [IDX_W-1:0]      cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [NOW_W-1:0]      s_now_ms,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAN_W-1:0]          m_out_red,
    output logic [CHAN_W-1:0]          m_out_green,
    output logic [CHAN_W-1:0]          m_out_blue
);

    cfg_t             cfg;
    logic             restart;
    fx_result_t       result;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [NOW_W-1:0] now_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    rgb_t             out_color_reg;
    logic             advance;

    rgbled_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg),
        .restart      (restart)
    );

    rgbled_fx u_fx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .now_ms  (now_reg),
        .cfg     (cfg),
        .restart (restart),
        .result  (result)
    );

    // handshake: input stage moves on when the output register has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg <= s_now_ms;
        end
        if (advance && result.emit) begin
            out_color_reg <= result.color;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_color_reg.red;
    assign m_out_green = out_color_reg.green;
    assign m_out_blue  = out_color_reg.blue;

endmodule

`default_nettype wire

/* hw/rtl/rgbled_cfg.sv */
// ---------------------------------------------------------------------------
// rgbled_cfg
// Configuration registers with speed saturation and effect restart strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbled_cfg
    import rgbled_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [IDX_W-1:0]      cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                       cfg,
    output logic                       restart
);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [SPEED_W-1:0] speed_sat;

    // clamp written speed into its legal range
    always_comb begin
        speed_sat = cfg_wr_data[SPEED_W-1:0];
        if (speed_sat < SPEED_MIN) begin
            speed_sat = SPEED_MIN;
        end else if (speed_sat > SPEED_MAX) begin
            speed_sat = SPEED_MAX;
        end
    end

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_EFFECT_MODE: begin
                    cfg_next.mode = mode_t'(cfg_wr_data[1:0]);
                    restart       = 1'b1;
                end
                REG_EFFECT_SPEED: begin
                    cfg_next.speed = speed_sat;
                    restart        = 1'b1;
                end
                REG_BASE_RED: begin
                    cfg_next.base.red = cfg_wr_data;
                end
                REG_BASE_GREEN: begin
                    cfg_next.base.green = cfg_wr_data;
                end
                REG_BASE_BLUE: begin
                    cfg_next.base.blue = cfg_wr_data;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode  <= MODE_SOLID;
            cfg_reg.speed <= SPEED_MIN;
            cfg_reg.base  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hw/rtl/rgbled_fx.sv */
// ---------------------------------------------------------------------------
// rgbled_fx
// Effect state (timer, blink, pulse, rainbow) and per-item color logic.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbled_fx
    import rgbled_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [NOW_W-1:0]  now_ms,
    input  wire cfg_t              cfg,
    input  wire logic              restart,
    output fx_result_t             result
);

    logic [NOW_W-1:0]      last_update_reg;
    logic [NOW_W-1:0]      last_update_next;
    logic                  blink_on_reg;
    logic                  blink_on_next;
    logic [CHAN_W-1:0]     pulse_level_reg;
    logic [CHAN_W-1:0]     pulse_level_next;
    logic                  pulse_rising_reg;
    logic                  pulse_rising_next;
    logic [CHAN_W-1:0]     rainbow_pos_reg;
    logic [CHAN_W-1:0]     rainbow_pos_next;

    logic [INTERVAL_W-1:0] interval;
    logic [NOW_W-1:0]      elapsed;
    logic                  due;
    logic [CHAN_W:0]       pulse_up;
    logic [CHAN_W-1:0]     level_step;
    logic                  rising_step;

    // update interval and elapsed time check
    assign interval = SLOW_BASE_MS
                    - ({{(INTERVAL_W-$bits(SPEED_STEP_MS)){1'b0}}, SPEED_STEP_MS}
                       * {{(INTERVAL_W-SPEED_W){1'b0}}, cfg.speed});
    assign elapsed  = now_ms - last_update_reg;
    assign due      = (cfg.mode != MODE_SOLID)
                    && (elapsed >= {{(NOW_W-INTERVAL_W){1'b0}}, interval});

    // pulse ramp with clamp and reversal
    assign pulse_up = {1'b0, pulse_level_reg} + {1'b0, PULSE_STEP};
    always_comb begin
        level_step  = pulse_level_reg;
        rising_step = pulse_rising_reg;
        if (pulse_rising_reg) begin
            if (pulse_up >= {1'b0, CHAN_MAX}) begin
                level_step  = CHAN_MAX;
                rising_step = 1'b0;
            end else begin
                level_step = pulse_up[CHAN_W-1:0];
            end
        end else begin
            if (pulse_level_reg <= PULSE_STEP) begin
                level_step  = '0;
                rising_step = 1'b1;
            end else begin
                level_step = pulse_level_reg - PULSE_STEP;
            end
        end
    end

    // color and next state for one item
    always_comb begin
        last_update_next  = last_update_reg;
        blink_on_next     = blink_on_reg;
        pulse_level_next  = pulse_level_reg;
        pulse_rising_next = pulse_rising_reg;
        rainbow_pos_next  = rainbow_pos_reg;
        result.emit       = advance && due;
        result.color      = '0;
        case (cfg.mode)
            MODE_BLINK: begin
                if (!blink_on_reg) begin
                    result.color = cfg.base;
                end
            end
            MODE_PULSE: begin
                result.color.red   = scale_chan(cfg.base.red, level_step);
                result.color.green = scale_chan(cfg.base.green, level_step);
                result.color.blue  = scale_chan(cfg.base.blue, level_step);
            end
            MODE_RAINBOW: begin
                result.color = color_wheel(rainbow_pos_reg);
            end
            default: begin
                result.color = '0;
            end
        endcase
        if (restart) begin
            last_update_next  = '0;
            blink_on_next     = 1'b1;
            pulse_level_next  = '0;
            pulse_rising_next = 1'b1;
        end else if (result.emit) begin
            last_update_next = now_ms;
            case (cfg.mode)
                MODE_BLINK: begin
                    blink_on_next = !blink_on_reg;
                end
                MODE_PULSE: begin
                    pulse_level_next  = level_step;
                    pulse_rising_next = rising_step;
                end
                MODE_RAINBOW: begin
                    rainbow_pos_next = rainbow_pos_reg + RAINBOW_STEP;
                end
                default: begin
                    last_update_next = now_ms;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_update_reg  <= '0;
            blink_on_reg     <= 1'b1;
            pulse_level_reg  <= '0;
            pulse_rising_reg <= 1'b1;
            rainbow_pos_reg  <= '0;
        end else begin
            last_update_reg  <= last_update_next;
            blink_on_reg     <= blink_on_next;
            pulse_level_reg  <= pulse_level_next;
            pulse_rising_reg <= pulse_rising_next;
            rainbow_pos_reg  <= rainbow_pos_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rgbled_checker.sv */
// ---------------------------------------------------------------------------
// rgbled_checker
// Port-level checks for the RGB LED effect generator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbled_checker
    import rgbled_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [CHAN_W-1:0] m_out_red,
    input wire logic [CHAN_W-1:0] m_out_green,
    input wire logic [CHAN_W-1:0] m_out_blue
);

    // a stalled result item holds its color
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red)
                                && $stable(m_out_green) && $stable(m_out_blue))
        else $error("result item changed while stalled");

    // with the output empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a new result comes from an item that was accepted and passed the input register
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result item without a matching input item");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind rgb_led_effect_generator_unit rgbled_checker u_rgbled_checker (.*);

`default_nettype wire

/* tb/rgb_led_effect_generator_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_led_effect_generator_unit_tb
// Self-checking bench for the timestamp-driven blink, pulse and rainbow unit.
// ---------------------------------------------------------------------------
// Timestamps are sent in random bursts while the color side stalls on a
// changing pattern. A behavioral copy of the effect state predicts each color
// item when its timestamp is accepted; every color item that comes out is
// checked field by field against the oldest prediction. Directed cases cover
// solid mode, ignored register indexes, speed saturation, blink, the pulse
// clamp at full level and the rainbow wheel across a timestamp wrap; random
// phases then reprogram the unit and push mostly well-paced timestamps.
// ---------------------------------------------------------------------------

module rgb_led_effect_generator_unit_tb;

    import rgbled_pkg::*;

    localparam int unsigned HALF_PERIOD_NS   = 4;
    localparam int unsigned RESET_CYCLES     = 7;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS     = 650;

    localparam int unsigned BASE_INTERVAL_MS = 620;
    localparam int unsigned INTERVAL_STEP_MS = 52;
    localparam int unsigned LEVEL_STEP       = 24;
    localparam int unsigned LEVEL_TOP        = 255;
    localparam int unsigned WHEEL_THIRD      = 85;
    localparam int unsigned WHEEL_TWO_THIRDS = 170;
    localparam int unsigned HUE_STEP         = 8;
    localparam logic [SPEED_W-1:0] SPEED_BOTTOM = 4'd1;
    localparam logic [SPEED_W-1:0] SPEED_TOP    = 4'd10;

    // indexes past the last register, writes there must be dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_SPARSE
    } ready_pattern_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [IDX_W-1:0]      cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [NOW_W-1:0]      s_now_ms;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_out_red;
    logic [CHAN_W-1:0]     m_out_green;
    logic [CHAN_W-1:0]     m_out_blue;

    // predicted effect configuration and state
    mode_t             fx_mode;
    logic [SPEED_W-1:0] fx_speed;
    rgb_t              fx_base;
    logic [NOW_W-1:0]  last_stamp;
    logic              blink_lit;
    logic [CHAN_W-1:0] pulse_lvl;
    logic              pulse_up;
    logic [CHAN_W-1:0] wheel_pos;

    rgb_t expected_colors[$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    int   pattern_left = 0;
    int   ready_tick = 0;
    ready_pattern_t ready_pattern = READY_ALWAYS;

    rgb_led_effect_generator_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue)
    );

    // clock
    always begin
        #(HALF_PERIOD_NS) aclk = 1'b1;
        #(HALF_PERIOD_NS) aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // effect prediction
    // ------------------------------------------------------------------

    function automatic logic [NOW_W-1:0] interval_of(input logic [SPEED_W-1:0] spd);
        return BASE_INTERVAL_MS - INTERVAL_STEP_MS * spd;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_scaled(input logic [CHAN_W-1:0] chan,
                                                      input logic [CHAN_W-1:0] lvl);
        int unsigned prod;
        prod = (chan * lvl) / LEVEL_TOP;
        return prod[CHAN_W-1:0];
    endfunction

    // wheel is walked backwards from the top position
    function automatic rgb_t wheel_color(input logic [CHAN_W-1:0] pos);
        int unsigned hue;
        int unsigned up;
        rgb_t        c;
        hue = LEVEL_TOP - pos;
        if (hue < WHEEL_THIRD) begin
            up = 3 * hue;
            c.red   = CHAN_W'(LEVEL_TOP - up);
            c.green = '0;
            c.blue  = up[CHAN_W-1:0];
        end else if (hue < WHEEL_TWO_THIRDS) begin
            up = 3 * (hue - WHEEL_THIRD);
            c.red   = '0;
            c.green = up[CHAN_W-1:0];
            c.blue  = CHAN_W'(LEVEL_TOP - up);
        end else begin
            up = 3 * (hue - WHEEL_TWO_THIRDS);
            c.red   = up[CHAN_W-1:0];
            c.green = CHAN_W'(LEVEL_TOP - up);
            c.blue  = '0;
        end
        return c;
    endfunction

    task automatic restart_timers();
        last_stamp = '0;
        blink_lit  = 1'b1;
        pulse_lvl  = '0;
        pulse_up   = 1'b1;
    endtask

    task automatic reset_effect_model();
        fx_mode   = MODE_SOLID;
        fx_speed  = SPEED_BOTTOM;
        fx_base   = '0;
        wheel_pos = '0;
        restart_timers();
    endtask

    task automatic apply_reg_write(input logic [IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        logic [SPEED_W-1:0] spd;
        case (idx)
            REG_EFFECT_MODE: begin
                fx_mode = mode_t'(data[1:0]);
                restart_timers();
            end
            REG_EFFECT_SPEED: begin
                spd = data[SPEED_W-1:0];
                if (spd < SPEED_BOTTOM) begin
                    spd = SPEED_BOTTOM;
                end else if (spd > SPEED_TOP) begin
                    spd = SPEED_TOP;
                end
                fx_speed = spd;
                restart_timers();
            end
            REG_BASE_RED:   fx_base.red   = data[CHAN_W-1:0];
            REG_BASE_GREEN: fx_base.green = data[CHAN_W-1:0];
            REG_BASE_BLUE:  fx_base.blue  = data[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    // advance the effect for one timestamp, queue a color if one is due
    task automatic predict_color(input logic [NOW_W-1:0] stamp);
        logic [NOW_W-1:0]  elapsed;
        logic [CHAN_W:0]   next_lvl;
        rgb_t              c;
        if (fx_mode == MODE_SOLID) begin
            return;
        end
        elapsed = stamp - last_stamp;
        if (elapsed < interval_of(fx_speed)) begin
            return;
        end
        last_stamp = stamp;
        c = '0;
        case (fx_mode)
            MODE_BLINK: begin
                blink_lit = !blink_lit;
                if (blink_lit) begin
                    c = fx_base;
                end
            end
            MODE_PULSE: begin
                if (pulse_up) begin
                    next_lvl = (CHAN_W+1)'(pulse_lvl + LEVEL_STEP);
                    if (next_lvl >= LEVEL_TOP) begin
                        pulse_lvl = CHAN_W'(LEVEL_TOP);
                        pulse_up  = 1'b0;
                    end else begin
                        pulse_lvl = next_lvl[CHAN_W-1:0];
                    end
                end else if (pulse_lvl <= LEVEL_STEP) begin
                    pulse_lvl = '0;
                    pulse_up  = 1'b1;
                end else begin
                    pulse_lvl = CHAN_W'(pulse_lvl - LEVEL_STEP);
                end
                c.red   = chan_scaled(fx_base.red, pulse_lvl);
                c.green = chan_scaled(fx_base.green, pulse_lvl);
                c.blue  = chan_scaled(fx_base.blue, pulse_lvl);
            end
            default: begin
                c = wheel_color(wheel_pos);
                wheel_pos = CHAN_W'(wheel_pos + HUE_STEP);
            end
        endcase
        expected_colors.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        apply_reg_write(idx, data);
    endtask

    task automatic cfg_release();
        cfg_wr_en <= 1'b0;
    endtask

    // one timestamp item, with a random gap at the start of each burst
    task automatic send_stamp(input logic [NOW_W-1:0] stamp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_now_ms <= stamp;
        do @(posedge aclk); while (!s_ready);
        predict_color(stamp);
    endtask

    // let every queued color drain, then cover items still in flight
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // color side: stall pattern and checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            ready_pattern = ready_pattern_t'($urandom_range(0, 3));
            pattern_left  = $urandom_range(16, 96);
        end
        pattern_left--;
        ready_tick++;
        case (ready_pattern)
            READY_ALWAYS:       m_ready <= 1'b1;
            READY_COIN:         m_ready <= ($urandom_range(0, 1) == 1);
            READY_EVERY_FOURTH: m_ready <= (ready_tick % 4 == 0);
            default:            m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_colors
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected color item",
                                {8'h00, m_out_red, m_out_green, m_out_blue}, '0);
            end else begin
                want = expected_colors.pop_front();
                if (m_out_red !== want.red) begin
                    report_mismatch("out_red", 32'(m_out_red), 32'(want.red));
                end
                if (m_out_green !== want.green) begin
                    report_mismatch("out_green", 32'(m_out_green), 32'(want.green));
                end
                if (m_out_blue !== want.blue) begin
                    report_mismatch("out_blue", 32'(m_out_blue), 32'(want.blue));
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_led_effect_generator_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // solid mode stays dark whatever the time, writes past the map are dropped
    task automatic test_solid_and_unmapped();
        write_reg(REG_BASE_RED, 8'hFF);
        write_reg(REG_BASE_GREEN, 8'h00);
        write_reg(REG_BASE_BLUE, 8'h5A);
        write_reg(REG_UNMAPPED_LO, 8'hFF);
        write_reg(REG_UNMAPPED_HI, 8'hA5);
        write_reg(REG_EFFECT_MODE, {6'h3F, MODE_SOLID});
        cfg_release();
        send_stamp(32'h0000_0000);
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'h8000_0000);
    endtask

    // blink at the slowest speed, one ms short of the interval and exactly on it
    task automatic test_blink();
        wait_idle();
        write_reg(REG_EFFECT_MODE, {6'h3F, MODE_BLINK});
        write_reg(REG_EFFECT_SPEED, 8'h00);
        cfg_release();
        send_stamp(32'd567);
        send_stamp(32'd568);
        send_stamp(32'd1135);
        send_stamp(32'd1136);
    endtask

    // pulse at the fastest speed, ramps up into the clamp at full level
    task automatic test_pulse_clamp();
        wait_idle();
        write_reg(REG_BASE_RED, 8'hFF);
        write_reg(REG_BASE_GREEN, 8'h80);
        write_reg(REG_BASE_BLUE, 8'h01);
        write_reg(REG_EFFECT_MODE, {6'h00, MODE_PULSE});
        write_reg(REG_EFFECT_SPEED, 8'hFF);
        cfg_release();
        for (int k = 1; k <= 12; k++) begin
            send_stamp(100 * k);
        end
    endtask

    // rainbow with the elapsed time wrapping through zero
    task automatic test_rainbow_wrap();
        wait_idle();
        write_reg(REG_EFFECT_MODE, {6'h2A, MODE_RAINBOW});
        write_reg(REG_EFFECT_SPEED, 8'h0B);
        cfg_release();
        send_stamp(32'hFFFF_FFF0);
        send_stamp(32'h0000_0054);
        send_stamp(32'h0000_00B7);
        send_stamp(32'h0000_00B8);
    endtask

    // random settings, mostly well-paced timestamps with early ones and noise
    task automatic test_random_traffic();
        int                    counted;
        int                    phase;
        int                    n;
        int                    r;
        logic                  restart;
        logic [CFG_DATA_W-1:0] mode_data;
        logic [CFG_DATA_W-1:0] speed_data;
        logic [NOW_W-1:0]      stamp;
        logic [NOW_W-1:0]      span;
        counted = 0;
        phase   = 0;
        stamp   = '0;
        while (counted < RANDOM_ITEMS) begin
            wait_idle();
            write_reg(REG_BASE_RED, random_chan());
            write_reg(REG_BASE_GREEN, random_chan());
            write_reg(REG_BASE_BLUE, random_chan());
            if ($urandom_range(0, 3) == 0) begin
                write_reg(IDX_W'(REG_UNMAPPED_LO + $urandom_range(0, 2)),
                          CFG_DATA_W'($urandom_range(0, 255)));
            end
            // a base-only phase keeps the running effect going
            restart = (phase == 0) || ($urandom_range(0, 3) != 0);
            if (restart) begin
                mode_data  = CFG_DATA_W'($urandom_range(0, 255));
                mode_data[1:0] = ($urandom_range(0, 7) == 0) ? MODE_SOLID
                                                             : mode_t'($urandom_range(1, 3));
                speed_data = CFG_DATA_W'($urandom_range(0, 255));
                if (phase % 5 == 1) begin
                    speed_data[SPEED_W-1:0] = SPEED_BOTTOM;
                end else if (phase % 5 == 2) begin
                    speed_data[SPEED_W-1:0] = SPEED_TOP;
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(REG_EFFECT_MODE, mode_data);
                    write_reg(REG_EFFECT_SPEED, speed_data);
                end else begin
                    write_reg(REG_EFFECT_SPEED, speed_data);
                    write_reg(REG_EFFECT_MODE, mode_data);
                end
                case ($urandom_range(0, 2))
                    0:       stamp = $urandom_range(0, 1500);
                    1:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 1500);
                    default: stamp = $urandom();
                endcase
            end
            cfg_release();
            span = interval_of(fx_speed);
            n = (fx_mode == MODE_SOLID) ? 8 : $urandom_range(30, 90);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    stamp = stamp + span + $urandom_range(0, span / 2);
                end else if (r < 70) begin
                    stamp = stamp + span - $urandom_range(0, 1);
                end else if (r < 90) begin
                    stamp = stamp + $urandom_range(0, span - 1);
                end else begin
                    stamp = $urandom();
                end
                send_stamp(stamp);
                if (fx_mode != MODE_SOLID) begin
                    counted++;
                end
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_now_ms     <= '0;
        reset_effect_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_solid_and_unmapped();
        test_blink();
        test_pulse_clamp();
        test_rainbow_wrap();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("rgb_led_effect_generator_unit_tb: PASS");
        end else begin
            $display("rgb_led_effect_generator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
